// File: hdl/rtcsp_pkg.sv
package rtcsp_pkg;

    // pin register bit positions
    localparam int unsigned PIN_IO     = 0;
    localparam int unsigned PIN_CLOCK  = 1;
    localparam int unsigned PIN_SELECT = 2;
    localparam int unsigned PIN_DIR    = 4;

    // status one: 24-hour mode bit
    localparam int unsigned MODE_24H = 1;

    // command types, bits 6..4 of the command byte
    typedef enum logic [2:0] {
        CMD_STATUS_ONE = 3'd0,
        CMD_DATE_TIME  = 3'd2,
        CMD_STATUS_TWO = 3'd4,
        CMD_TIME       = 3'd6
    } cmd_type_t;

    localparam logic [7:0] COUNT_MAX = 8'hFF;

    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } rtc_time_t;

    // binary to BCD for values below 100; tens by reciprocal multiply
    function automatic logic [7:0] to_bcd(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        begin
            prod = 15'(x) * 15'd205;
            tens = prod[14:11];
            ones = x - 7'(tens) * 7'd10;
            to_bcd = {tens, ones[3:0]};
        end
    endfunction

    // hour in 12- or 24-hour form, as BCD
    function automatic logic [7:0] hour_bcd(input logic [4:0] h, input logic mode_24h);
        logic [4:0] x;
        begin
            x = h;
            if (!mode_24h)
            begin
                if (x >= 5'd24)
                    x = x - 5'd24;
                else if (x >= 5'd12)
                    x = x - 5'd12;
            end
            hour_bcd = to_bcd({2'b00, x});
        end
    endfunction

endpackage

// File: hdl/three_wire_rtc_serial_port.sv
// Three-wire serial RTC port driven by pin register writes.
// Input channel (in_valid/in_ready): one transfer is a write of pin_byte
// (io bit 0, clock bit 1, select bit 2, direction bit 4) together with the
// current binary date and time. A falling clock edge with select high moves
// one bit: the first eight form the command byte, later ones write or read
// status registers, or read the BCD date and time.
// Output channel (out_valid/out_ready): one transfer per input, carrying the
// new pin register in pin_readback; on a read bit, bit 0 holds the data.
// The result is registered and appears in the cycle after acceptance.
// One item is taken per cycle while the receiver keeps up; the pin register
// itself is the result register, so decode, BCD conversion and bit select are combinational.
// While a result waits on a stalled receiver, in_ready stays low; it rises
// again in the same cycle that the receiver takes the result.
// Reset clears the pin register, bit counter, command byte and both status
// registers, and empties the output.
module three_wire_rtc_serial_port
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pin_byte,
    input  logic [6:0]  year,
    input  logic [3:0]  month,
    input  logic [4:0]  day,
    input  logic [2:0]  weekday,
    input  logic [4:0]  hour,
    input  logic [5:0]  minute,
    input  logic [5:0]  second,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  pin_readback
);

    logic [7:0] pin_latch_reg, pin_latch_next;
    logic [7:0] bit_counter_reg, bit_counter_next;
    logic [7:0] command_reg, command_next;
    logic [7:0] status_one_reg, status_one_next;
    logic [7:0] status_two_reg, status_two_next;
    logic       out_valid_reg, out_valid_next;

    logic                  accept;
    logic                  falling;
    logic                  read_bit;
    rtcsp_pkg::rtc_time_t  now;

    assign in_ready     = !out_valid_reg || out_ready;
    assign accept       = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign pin_readback = pin_latch_reg;

    assign now.year    = year;
    assign now.month   = month;
    assign now.day     = day;
    assign now.weekday = weekday;
    assign now.hour    = hour;
    assign now.minute  = minute;
    assign now.second  = second;

    assign falling = pin_latch_reg[rtcsp_pkg::PIN_CLOCK] && !pin_byte[rtcsp_pkg::PIN_CLOCK];

    rtcsp_read_sel u_read_sel
    (
        .command    (command_reg),
        .bit_count  (bit_counter_reg),
        .status_one (status_one_reg),
        .status_two (status_two_reg),
        .now        (now),
        .read_bit   (read_bit)
    );

    always_comb
    begin
        pin_latch_next   = pin_latch_reg;
        bit_counter_next = bit_counter_reg;
        command_next     = command_reg;
        status_one_next  = status_one_reg;
        status_two_next  = status_two_reg;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (accept)
        begin
            out_valid_next = 1'b1;
            pin_latch_next = pin_byte;
            if (pin_byte[rtcsp_pkg::PIN_SELECT])
            begin
                if (falling)
                begin
                    if (bit_counter_reg < 8'd8)
                    begin
                        command_next[bit_counter_reg[2:0]] =
                            command_reg[bit_counter_reg[2:0]] | pin_byte[rtcsp_pkg::PIN_IO];
                    end
                    else if (pin_byte[rtcsp_pkg::PIN_DIR])
                    begin
                        if (command_reg[6:4] == rtcsp_pkg::CMD_STATUS_ONE)
                            status_one_next[bit_counter_reg[2:0]] = pin_byte[rtcsp_pkg::PIN_IO];
                        else if (command_reg[6:4] == rtcsp_pkg::CMD_STATUS_TWO)
                            status_two_next[bit_counter_reg[2:0]] = pin_byte[rtcsp_pkg::PIN_IO];
                    end
                    else
                    begin
                        pin_latch_next[rtcsp_pkg::PIN_IO] = read_bit;
                    end
                    // saturate at the top
                    if (bit_counter_reg != rtcsp_pkg::COUNT_MAX)
                        bit_counter_next = bit_counter_reg + 8'd1;
                end
                else if (!pin_byte[rtcsp_pkg::PIN_DIR])
                begin
                    // hold the io level while the host reads
                    pin_latch_next[rtcsp_pkg::PIN_IO] = pin_latch_reg[rtcsp_pkg::PIN_IO];
                end
            end
            else
            begin
                bit_counter_next = 8'd0;
                command_next     = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_latch_reg   <= 8'd0;
            bit_counter_reg <= 8'd0;
            command_reg     <= 8'd0;
            status_one_reg  <= 8'd0;
            status_two_reg  <= 8'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            pin_latch_reg   <= pin_latch_next;
            bit_counter_reg <= bit_counter_next;
            command_reg     <= command_next;
            status_one_reg  <= status_one_next;
            status_two_reg  <= status_two_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    a_select_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !pin_byte[rtcsp_pkg::PIN_SELECT]
        |=> bit_counter_reg == 8'd0 && command_reg == 8'd0)
        else $error("select drop did not clear counter and command");

    a_counter_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        accept && pin_byte[rtcsp_pkg::PIN_SELECT]
        |=> bit_counter_reg >= $past(bit_counter_reg))
        else $error("bit counter went backwards while selected");

    a_upper_pins_follow: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg && pin_latch_reg[7:1] == $past(pin_byte[7:1]))
        else $error("result missing or upper pins differ from written byte");

    a_status_quiet_in_command: assert property (@(posedge clk) disable iff (!rst_n)
        accept && $past(bit_counter_reg) < 8'd8 && bit_counter_reg < 8'd8
        |=> $stable(status_one_reg) && $stable(status_two_reg))
        else $error("status register changed during the command byte");

endmodule

// File: hdl/rtcsp_read_sel.sv
module rtcsp_read_sel
(
    input  logic [7:0]             command,
    input  logic [7:0]             bit_count,
    input  logic [7:0]             status_one,
    input  logic [7:0]             status_two,
    input  rtcsp_pkg::rtc_time_t   now,
    output logic                   read_bit
);

    logic [4:0] slot;
    logic [3:0] sum7;
    logic [2:0] slot7;
    logic [2:0] sum3;
    logic [1:0] slot3;
    logic [7:0] src;
    logic [7:0] hour_val;

    // slot is one less than the byte number; counter is at least 8 here
    assign slot = bit_count[7:3] - 5'd1;

    always_comb
    begin
        // 8 is 1 mod 7, 4 is 1 mod 3: fold the digits, then trim
        sum7 = 4'(slot[4:3]) + 4'(slot[2:0]);
        if (sum7 >= 4'd7)
            sum7 = sum7 - 4'd7;
        slot7 = sum7[2:0];

        sum3 = 3'(slot[1:0]) + 3'(slot[3:2]) + 3'(slot[4]);
        if (sum3 >= 3'd3)
            sum3 = sum3 - 3'd3;
        if (sum3 >= 3'd3)
            sum3 = sum3 - 3'd3;
        slot3 = sum3[1:0];
    end

    assign hour_val = rtcsp_pkg::hour_bcd(now.hour, status_one[rtcsp_pkg::MODE_24H]);

    always_comb
    begin
        src      = 8'h00;
        read_bit = 1'b0;
        case (command[6:4])
            rtcsp_pkg::CMD_STATUS_ONE:
            begin
                src = status_one;
            end
            rtcsp_pkg::CMD_STATUS_TWO:
            begin
                src = status_two;
            end
            rtcsp_pkg::CMD_DATE_TIME:
            begin
                case (slot7)
                    3'd0:    src = rtcsp_pkg::to_bcd(now.year);
                    3'd1:    src = rtcsp_pkg::to_bcd({3'b000, now.month});
                    3'd2:    src = rtcsp_pkg::to_bcd({2'b00, now.day});
                    3'd3:    src = rtcsp_pkg::to_bcd({4'b0000, now.weekday});
                    3'd4:    src = hour_val;
                    3'd5:    src = rtcsp_pkg::to_bcd({1'b0, now.minute});
                    default: src = rtcsp_pkg::to_bcd({1'b0, now.second});
                endcase
            end
            rtcsp_pkg::CMD_TIME:
            begin
                case (slot3)
                    2'd0:    src = hour_val;
                    2'd1:    src = rtcsp_pkg::to_bcd({1'b0, now.minute});
                    default: src = rtcsp_pkg::to_bcd({1'b0, now.second});
                endcase
            end
            default:
            begin
                src = 8'h00;
            end
        endcase
        read_bit = src[bit_count[2:0]];
    end

endmodule
